>>> hw/rtl/assert_macros.svh
// assertion macros shared by the interval timer rtl
// depends on a clk_i and an active-low rst_ni in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hw/rtl/itc_pkg.sv
// shared types, codes and helper functions of the interval timer controller
// no dependencies
`timescale 1ns / 1ps

package itc_pkg;

  // timing constants
  localparam logic [31:0] MS_PER_SECOND   = 32'd1000;
  localparam logic [5:0]  LAST_SECOND     = 6'd59;

  // button event codes
  localparam logic [1:0] PRESS_NONE  = 2'd0;
  localparam logic [1:0] PRESS_SHORT = 2'd1;
  localparam logic [1:0] PRESS_LONG  = 2'd2;

  // sound codes
  localparam logic [1:0] SND_NONE    = 2'd0;
  localparam logic [1:0] SND_CONFIRM = 2'd1;
  localparam logic [1:0] SND_ALARM   = 2'd2;
  localparam logic [1:0] SND_DONE    = 2'd3;

  // display kinds
  localparam logic [1:0] DISP_BLANK  = 2'd0;
  localparam logic [1:0] DISP_NUMBER = 2'd1;
  localparam logic [1:0] DISP_COUNT  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WORK_LOW   = 2'd0;
  localparam logic [1:0] CFG_WORK_HIGH  = 2'd1;
  localparam logic [1:0] CFG_BREAK_LOW  = 2'd2;
  localparam logic [1:0] CFG_BREAK_HIGH = 2'd3;

  // configuration reset values
  localparam logic [7:0] WORK_LOW_RST   = 8'd1;
  localparam logic [7:0] WORK_HIGH_RST  = 8'd60;
  localparam logic [7:0] BREAK_LOW_RST  = 8'd1;
  localparam logic [7:0] BREAK_HIGH_RST = 8'd30;

  // interval reset values
  localparam logic [7:0] WORK_MIN_RST  = 8'd25;
  localparam logic [7:0] BREAK_MIN_RST = 8'd5;

  // input request
  typedef struct packed {
    logic              mode;
    logic signed [7:0] encoder_delta;
    logic [1:0]        button;
    logic [31:0]       now_ms;
    logic [7:0]        stored_work_minutes;
    logic [7:0]        stored_break_minutes;
  } itc_in_t;

  // result request
  typedef struct packed {
    logic [2:0] phase;
    logic       lamp;
    logic [1:0] display_kind;
    logic [7:0] display_minutes;
    logic [5:0] display_seconds;
    logic       colon;
    logic [1:0] sound;
    logic       save_presets;
    logic       session_credit;
    logic [7:0] work_minutes;
    logic [7:0] break_minutes;
  } itc_out_t;

  // interval limits from the configuration registers
  typedef struct packed {
    logic [7:0] work_lo;
    logic [7:0] work_hi;
    logic [7:0] brk_lo;
    logic [7:0] brk_hi;
  } itc_limits_t;

  // countdown state, kept as minutes and seconds
  typedef struct packed {
    logic [31:0] anchor;
    logic [7:0]  minutes;
    logic [5:0]  seconds;
    logic        colon;
  } itc_cd_t;

  // add a signed delta, raise to lo first, then cut to hi
  function automatic logic [7:0] clamp_add(logic [7:0] v, logic signed [7:0] delta,
                                           logic [7:0] lo, logic [7:0] hi);
    logic signed [9:0] n;
    logic signed [9:0] lo_s;
    logic signed [9:0] hi_s;
    n    = signed'({2'b00, v}) + signed'({{2{delta[7]}}, delta});
    lo_s = signed'({2'b00, lo});
    hi_s = signed'({2'b00, hi});
    if (n < lo_s) n = lo_s;
    if (n > hi_s) n = hi_s;
    return n[7:0];
  endfunction

endpackage

>>> hw/rtl/interval_timer_controller.sv
// interval timer controller top: input register, step core, result register
// a request is accepted into the input register, then stepped by the core into the result register
// throughput: one request per cycle, input stalls only when both registers are full
// and the result is held
// reset: async active low, phase idle, work 25 min, break 5 min, limits 1/60/1/30
`timescale 1ns / 1ps
`include "assert_macros.svh"

module interval_timer_controller import itc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  itc_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output itc_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic        in_valid_q, in_valid_d;
  itc_in_t     in_q;
  logic        out_valid_q, out_valid_d;
  logic        advance;
  logic        fire;
  logic        accept;
  itc_limits_t limits;

  // pipeline flow control
  assign advance     = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;
  assign in_valid_d  = accept || (in_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && out_stall_i);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  itc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .limits_o   (limits)
  );

  itc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_q),
    .limits_i (limits),
    .result_o (out_data_o)
  );

  assign out_valid_o = out_valid_q;

  // checks
  `ASSERT_ALWAYS(a_fire_fills_output, fire |=> out_valid_q, "processed request lost")
  `ASSERT_NEVER(a_stall_needs_full, in_stall_o && !(in_valid_q && out_valid_q && out_stall_i), "stall")
  `ASSERT_ALWAYS(a_output_drains, out_valid_q && !out_stall_i && !in_valid_q |=> !out_valid_q, "repeat")

endmodule

>>> hw/rtl/itc_cfg.sv
// limit registers of the interval timer controller
// depends on itc_pkg
`timescale 1ns / 1ps

module itc_cfg import itc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  logic [1:0]  wr_index_i,
  input  logic [7:0]  wr_data_i,
  output itc_limits_t limits_o
);

  itc_limits_t limits_q, limits_d;

  // register write decode
  always_comb begin
    limits_d = limits_q;
    if (wr_en_i) begin
      case (wr_index_i)
        CFG_WORK_LOW:   limits_d.work_lo = wr_data_i;
        CFG_WORK_HIGH:  limits_d.work_hi = wr_data_i;
        CFG_BREAK_LOW:  limits_d.brk_lo  = wr_data_i;
        CFG_BREAK_HIGH: limits_d.brk_hi  = wr_data_i;
        default:        limits_d = limits_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q <= '{work_lo: WORK_LOW_RST, work_hi: WORK_HIGH_RST,
                    brk_lo: BREAK_LOW_RST, brk_hi: BREAK_HIGH_RST};
    end else begin
      limits_q <= limits_d;
    end
  end

  assign limits_o = limits_q;

endmodule

>>> hw/rtl/itc_countdown.sv
// one-second tick of the countdown: elapsed check, anchor step, min/sec decrement
// depends on itc_pkg
`timescale 1ns / 1ps

module itc_countdown import itc_pkg::*; (
  input  itc_cd_t     cd_i,
  input  logic [31:0] now_ms_i,
  output logic        tick_o,
  output logic        zero_o,
  output itc_cd_t     cd_o
);

  logic [31:0] elapsed;

  // a second has gone by once the wrapped difference reaches 1000 ms
  assign elapsed = now_ms_i - cd_i.anchor;
  assign tick_o  = (elapsed >= MS_PER_SECOND);

  // advance anchor, toggle colon, count down one second, saturate at zero
  always_comb begin
    cd_o        = cd_i;
    cd_o.anchor = cd_i.anchor + MS_PER_SECOND;
    cd_o.colon  = ~cd_i.colon;
    if (cd_i.seconds != 6'd0) begin
      cd_o.seconds = cd_i.seconds - 6'd1;
    end else if (cd_i.minutes != 8'd0) begin
      cd_o.minutes = cd_i.minutes - 8'd1;
      cd_o.seconds = LAST_SECOND;
    end
  end

  assign zero_o = (cd_o.minutes == 8'd0) && (cd_o.seconds == 6'd0);

endmodule

>>> hw/rtl/itc_core.sv
// phase state machine, interval and countdown state, and the result register
// depends on itc_pkg, itc_countdown and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itc_core import itc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  itc_in_t     item_i,
  input  itc_limits_t limits_i,
  output itc_out_t    result_o
);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SET_WORK  = 3'd1,
    PH_SET_BREAK = 3'd2,
    PH_WORK      = 3'd3,
    PH_BREAK     = 3'd4
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] work_q, work_d;
  logic [7:0] brk_q, brk_d;
  itc_cd_t    cd_q, cd_d;
  logic       lamp_q, lamp_d;
  logic [1:0] kind_q, kind_d;
  logic [7:0] num_q, num_d;
  itc_out_t   result_q, result_d;

  logic       tick;
  logic       tick_zero;
  itc_cd_t    cd_tick;
  logic [1:0] sound;
  logic       save;
  logic       credit;

  itc_countdown u_countdown (
    .cd_i     (cd_q),
    .now_ms_i (item_i.now_ms),
    .tick_o   (tick),
    .zero_o   (tick_zero),
    .cd_o     (cd_tick)
  );

  // next state for one request
  always_comb begin
    phase_d = phase_q;
    work_d  = work_q;
    brk_d   = brk_q;
    cd_d    = cd_q;
    lamp_d  = lamp_q;
    kind_d  = kind_q;
    num_d   = num_q;
    sound   = SND_NONE;
    save    = 1'b0;
    credit  = 1'b0;

    if (item_i.mode) begin
      // load presets and enter set-work
      lamp_d  = 1'b0;
      work_d  = clamp_add(item_i.stored_work_minutes, 8'sd0,
                          limits_i.work_lo, limits_i.work_hi);
      brk_d   = clamp_add(item_i.stored_break_minutes, 8'sd0,
                          limits_i.brk_lo, limits_i.brk_hi);
      phase_d = PH_SET_WORK;
      kind_d  = DISP_NUMBER;
      num_d   = work_d;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          // any activity wakes up into set-work
          if (item_i.encoder_delta != 8'sd0 || item_i.button != PRESS_NONE) begin
            phase_d = PH_SET_WORK;
            kind_d  = DISP_NUMBER;
            num_d   = work_q;
          end
        end
        PH_SET_WORK: begin
          if (item_i.encoder_delta != 8'sd0) begin
            work_d = clamp_add(work_q, item_i.encoder_delta,
                               limits_i.work_lo, limits_i.work_hi);
            kind_d = DISP_NUMBER;
            num_d  = work_d;
          end
          if (item_i.button == PRESS_SHORT) begin
            sound   = SND_CONFIRM;
            phase_d = PH_SET_BREAK;
            kind_d  = DISP_NUMBER;
            num_d   = brk_q;
          end else if (item_i.button == PRESS_LONG) begin
            phase_d = PH_IDLE;
            lamp_d  = 1'b0;
            kind_d  = DISP_BLANK;
            num_d   = 8'd0;
          end
        end
        PH_SET_BREAK: begin
          if (item_i.encoder_delta != 8'sd0) begin
            brk_d  = clamp_add(brk_q, item_i.encoder_delta,
                               limits_i.brk_lo, limits_i.brk_hi);
            kind_d = DISP_NUMBER;
            num_d  = brk_d;
          end
          if (item_i.button == PRESS_SHORT) begin
            // start the work countdown
            save       = 1'b1;
            sound      = SND_CONFIRM;
            phase_d    = PH_WORK;
            lamp_d     = 1'b0;
            cd_d       = '{anchor: item_i.now_ms, minutes: work_q, seconds: 6'd0,
                           colon: 1'b1};
            kind_d     = DISP_COUNT;
          end else if (item_i.button == PRESS_LONG) begin
            phase_d = PH_IDLE;
            lamp_d  = 1'b0;
            kind_d  = DISP_BLANK;
            num_d   = 8'd0;
          end
        end
        PH_WORK: begin
          if (item_i.button == PRESS_LONG) begin
            phase_d = PH_IDLE;
            lamp_d  = 1'b0;
            kind_d  = DISP_BLANK;
            num_d   = 8'd0;
          end else if (tick) begin
            cd_d   = cd_tick;
            kind_d = DISP_COUNT;
            if (tick_zero) begin
              // work over: lamp on, alarm, credit, start the break
              lamp_d  = 1'b1;
              sound   = SND_ALARM;
              credit  = 1'b1;
              phase_d = PH_BREAK;
              cd_d    = '{anchor: item_i.now_ms, minutes: brk_q, seconds: 6'd0,
                          colon: 1'b1};
            end
          end
        end
        PH_BREAK: begin
          if (item_i.button == PRESS_LONG) begin
            sound   = SND_DONE;
            phase_d = PH_IDLE;
            lamp_d  = 1'b0;
            kind_d  = DISP_BLANK;
            num_d   = 8'd0;
          end else if (tick) begin
            cd_d   = cd_tick;
            kind_d = DISP_COUNT;
            if (tick_zero) begin
              sound   = SND_DONE;
              phase_d = PH_IDLE;
              lamp_d  = 1'b0;
              kind_d  = DISP_BLANK;
              num_d   = 8'd0;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
          lamp_d  = 1'b0;
          kind_d  = DISP_BLANK;
          num_d   = 8'd0;
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    result_d                 = '0;
    result_d.phase           = phase_d;
    result_d.lamp            = lamp_d;
    result_d.display_kind    = kind_d;
    result_d.sound           = sound;
    result_d.save_presets    = save;
    result_d.session_credit  = credit;
    result_d.work_minutes    = work_d;
    result_d.break_minutes   = brk_d;
    if (kind_d == DISP_NUMBER) begin
      result_d.display_minutes = num_d;
    end else if (kind_d == DISP_COUNT) begin
      result_d.display_minutes = cd_d.minutes;
      result_d.display_seconds = cd_d.seconds;
      result_d.colon           = cd_d.colon;
    end
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      work_q   <= WORK_MIN_RST;
      brk_q    <= BREAK_MIN_RST;
      cd_q     <= '{anchor: 32'd0, minutes: 8'd0, seconds: 6'd0, colon: 1'b1};
      lamp_q   <= 1'b0;
      kind_q   <= DISP_BLANK;
      num_q    <= 8'd0;
      result_q <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      work_q   <= work_d;
      brk_q    <= brk_d;
      cd_q     <= cd_d;
      lamp_q   <= lamp_d;
      kind_q   <= kind_d;
      num_q    <= num_d;
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

  // checks
  `ASSERT_ALWAYS(a_lamp_only_in_break, lamp_q |-> phase_q == PH_BREAK, "lamp on outside break")
  `ASSERT_ALWAYS(a_seconds_range, cd_q.seconds <= LAST_SECOND, "countdown seconds above 59")
  `ASSERT_ALWAYS(a_credit_enters_break, fire_i && credit |=> phase_q == PH_BREAK && lamp_q, "no break")

endmodule
